FILE: hw/rtl/vt4_pkg.sv
// shared types and constants for the 4x4 vertex transform core
// no dependencies; imported by every module of the core
package vt4_pkg;

    localparam int DATA_W = 32;

    // request kinds
    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_NORMAL = 2'd2,
        KIND_HOMOG  = 2'd3
    } t_kind;

    // per-request control and sums traveling with the data
    typedef struct packed {
        logic                         valid;
        t_kind                        kind;
        logic                         clip;
        logic                         wz;
        logic [3:0][DATA_W-1:0]       sum;
    } t_tag;

endpackage

FILE: hw/rtl/vt4_dot.sv
// row vector times 4x4 matrix: product stage and saturating column-sum stage
// depends on vt4_pkg
module vt4_dot import vt4_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_kind                    i_kind,
    input  logic signed [DATA_W-1:0] i_vec [4],
    input  logic signed [DATA_W-1:0] i_mat [16],
    output t_tag                     o_tag
);

    localparam int PW = 2 * DATA_W - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] MAXV = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] MINV = SW'(-64'sd2147483648);

    logic signed [2*DATA_W-1:0] w_full [16];
    logic signed [PW-1:0]       r_prod [16];
    logic                       r_valid;
    t_kind                      r_kind;
    logic signed [SW-1:0]       w_sum  [4];
    logic [DATA_W-1:0]          w_sat  [4];
    logic [3:0]                 w_clip;
    logic                       w_wz;
    t_tag                       n_tag;
    t_tag                       r_tag;

    // full products, floor shift by the fraction width
    for (genvar i = 0; i < 16; i++) begin : g_mul
        assign w_full[i] = i_vec[i/4] * i_mat[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_kind <= i_kind;
            for (int i = 0; i < 16; i++) begin
                r_prod[i] <= PW'(w_full[i] >>> FRAC_BITS);
            end
        end
    end

    // column sums and saturation
    for (genvar c = 0; c < 4; c++) begin : g_col
        assign w_sum[c] = SW'(r_prod[c]) + SW'(r_prod[4+c]) + SW'(r_prod[8+c])
                        + SW'(r_prod[12+c]);
        assign w_sat[c] = (w_sum[c] > MAXV) ? 32'h7FFF_FFFF :
                          (w_sum[c] < MINV) ? 32'h8000_0000 : w_sum[c][DATA_W-1:0];
        assign w_clip[c] = (w_sum[c] > MAXV) || (w_sum[c] < MINV);
    end

    assign w_wz = (r_kind == KIND_POINT) && (w_sat[3] == '0);

    always_comb begin
        n_tag.valid  = r_valid;
        n_tag.kind   = r_kind;
        n_tag.wz     = w_wz;
        n_tag.sum[0] = w_sat[0];
        n_tag.sum[1] = w_sat[1];
        n_tag.sum[2] = w_sat[2];
        n_tag.sum[3] = (r_kind == KIND_NORMAL) ? '0 : w_sat[3];
        n_tag.clip   = !w_wz && ((|w_clip[2:0])
                     || (w_clip[3] && (r_kind != KIND_NORMAL)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= n_tag;
        end
    end

    assign o_tag = r_tag;

endmodule

FILE: hw/rtl/vt4_div.sv
// pipelined restoring divider, one quotient bit per stage, three lanes
// sharing the w divisor; depends on vt4_pkg
module vt4_div import vt4_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_tag              i_tag,
    output t_tag              o_tag,
    output logic [2:0]        o_neg,
    output logic [DATA_W+FRAC_BITS-1:0] o_quot [3]
);

    localparam int NW = DATA_W + FRAC_BITS;

    t_tag              r_tag [NW];
    logic [DATA_W-1:0] r_den [NW];
    logic [2:0]        r_neg [NW];
    logic [DATA_W-1:0] r_rem [NW][3];
    logic [NW-1:0]     r_nq  [NW][3];

    logic [DATA_W-1:0] w_den;
    logic [2:0]        w_neg;
    logic [NW-1:0]     w_num [3];

    // operand magnitudes and quotient signs
    assign w_den = i_tag.sum[3][DATA_W-1] ? (~i_tag.sum[3] + 1'b1) : i_tag.sum[3];
    for (genvar l = 0; l < 3; l++) begin : g_in
        assign w_neg[l] = i_tag.sum[l][DATA_W-1] ^ i_tag.sum[3][DATA_W-1];
        assign w_num[l] = {(i_tag.sum[l][DATA_W-1] ? (~i_tag.sum[l] + 1'b1)
                                                    : i_tag.sum[l]),
                           {FRAC_BITS{1'b0}}};
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        t_tag              p_tag;
        logic [DATA_W-1:0] p_den;
        logic [2:0]        p_neg;
        logic [DATA_W-1:0] p_rem [3];
        logic [NW-1:0]     p_nq  [3];
        logic [DATA_W:0]   trial [3];
        logic [2:0]        ge;

        // previous stage or entry operands
        if (k == 0) begin : g_first
            assign p_tag = i_tag;
            assign p_den = w_den;
            assign p_neg = w_neg;
            for (genvar l = 0; l < 3; l++) begin : g_l
                assign p_rem[l] = '0;
                assign p_nq[l]  = w_num[l];
            end
        end else begin : g_next
            assign p_tag = r_tag[k-1];
            assign p_den = r_den[k-1];
            assign p_neg = r_neg[k-1];
            for (genvar l = 0; l < 3; l++) begin : g_l
                assign p_rem[l] = r_rem[k-1][l];
                assign p_nq[l]  = r_nq[k-1][l];
            end
        end

        // one trial subtraction per lane
        for (genvar l = 0; l < 3; l++) begin : g_step
            assign trial[l] = {p_rem[l], p_nq[l][NW-1]};
            assign ge[l]    = trial[l] >= {1'b0, p_den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k].valid <= 1'b0;
            end else if (i_en) begin
                r_tag[k] <= p_tag;
            end
            if (i_en) begin
                r_den[k] <= p_den;
                r_neg[k] <= p_neg;
                for (int l = 0; l < 3; l++) begin
                    r_rem[k][l] <= ge[l] ? DATA_W'(trial[l] - {1'b0, p_den})
                                         : trial[l][DATA_W-1:0];
                    r_nq[k][l]  <= {p_nq[l][NW-2:0], ge[l]};
                end
            end
        end
    end

    assign o_tag = r_tag[NW-1];
    assign o_neg = r_neg[NW-1];
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_quot[l] = r_nq[NW-1][l];
    end

endmodule

FILE: hw/rtl/vertex_transform_4x4_core.sv
// Q16.16 by default; requests pass input, dot, divider and output registers
// throughput: one request per cycle unless a held result stalls the pipeline
// the divider has one stage per quotient bit; loads update the matrix, give no result
// reset (synchronous, active low) empties the pipeline and sets the identity matrix
// depends on vt4_pkg, vt4_dot, vt4_div
module vertex_transform_4x4_core import vt4_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_kind,
    input  logic [3:0]               i_entry_index,
    input  logic signed [DATA_W-1:0] i_entry_value,
    input  logic signed [DATA_W-1:0] i_in_x,
    input  logic signed [DATA_W-1:0] i_in_y,
    input  logic signed [DATA_W-1:0] i_in_z,
    input  logic signed [DATA_W-1:0] i_in_w,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_out_x,
    output logic signed [DATA_W-1:0] o_out_y,
    output logic signed [DATA_W-1:0] o_out_z,
    output logic signed [DATA_W-1:0] o_out_w,
    output logic                     o_w_zero,
    output logic                     o_saturated
);

    localparam int NW = DATA_W + FRAC_BITS;
    localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(64'd1 << FRAC_BITS);

    logic                     adv;
    logic                     r_s1_valid;
    t_kind                    r_s1_kind;
    logic [3:0]               r_s1_idx;
    logic signed [DATA_W-1:0] r_s1_value;
    logic signed [DATA_W-1:0] r_s1_vec [4];
    logic signed [DATA_W-1:0] r_mat [16];
    logic signed [DATA_W-1:0] w_vec [4];
    t_tag                     dot_tag;
    t_tag                     div_tag;
    logic [2:0]               div_neg;
    logic [NW-1:0]            div_quot [3];
    logic [DATA_W-1:0]        w_q   [3];
    logic [2:0]               w_qclip;
    logic                     r_valid;
    logic [DATA_W-1:0]        r_res [4];
    logic                     r_wz;
    logic                     r_clip;

    // whole pipeline moves unless a finished result is held off
    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;

    // input register and matrix write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE_FX : '0;
            end
        end else if (adv) begin
            r_s1_valid <= i_valid;
            if (r_s1_valid && (r_s1_kind == KIND_LOAD)) begin
                r_mat[r_s1_idx] <= r_s1_value;
            end
        end
        if (adv && i_valid) begin
            r_s1_kind   <= t_kind'(i_kind);
            r_s1_idx    <= i_entry_index;
            r_s1_value  <= i_entry_value;
            r_s1_vec[0] <= i_in_x;
            r_s1_vec[1] <= i_in_y;
            r_s1_vec[2] <= i_in_z;
            r_s1_vec[3] <= i_in_w;
        end
    end

    // w term: one for points, input w for homogeneous, none for normals
    always_comb begin
        w_vec[0] = r_s1_vec[0];
        w_vec[1] = r_s1_vec[1];
        w_vec[2] = r_s1_vec[2];
        unique case (r_s1_kind)
            KIND_POINT: w_vec[3] = ONE_FX;
            KIND_HOMOG: w_vec[3] = r_s1_vec[3];
            default:    w_vec[3] = '0;
        endcase
    end

    vt4_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s1_valid && (r_s1_kind != KIND_LOAD)),
        .i_kind  (r_s1_kind),
        .i_vec   (w_vec),
        .i_mat   (r_mat),
        .o_tag   (dot_tag)
    );

    vt4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_tag   (dot_tag),
        .o_tag   (div_tag),
        .o_neg   (div_neg),
        .o_quot  (div_quot)
    );

    // quotient sign and saturation
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (div_neg[l]) begin
                w_qclip[l] = (|div_quot[l][NW-1:DATA_W])
                          || (div_quot[l][DATA_W-1] && (|div_quot[l][DATA_W-2:0]));
                w_q[l]     = w_qclip[l] ? 32'h8000_0000
                                        : (~div_quot[l][DATA_W-1:0] + 1'b1);
            end else begin
                w_qclip[l] = |div_quot[l][NW-1:DATA_W-1];
                w_q[l]     = w_qclip[l] ? 32'h7FFF_FFFF : div_quot[l][DATA_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= div_tag.valid;
        end
        if (adv) begin
            r_wz <= div_tag.wz;
            if (div_tag.kind == KIND_POINT) begin
                r_res[3] <= '0;
                if (div_tag.wz) begin
                    r_res[0] <= '0;
                    r_res[1] <= '0;
                    r_res[2] <= '0;
                    r_clip   <= 1'b0;
                end else begin
                    r_res[0] <= w_q[0];
                    r_res[1] <= w_q[1];
                    r_res[2] <= w_q[2];
                    r_clip   <= div_tag.clip || (|w_qclip);
                end
            end else begin
                for (int c = 0; c < 4; c++) begin
                    r_res[c] <= div_tag.sum[c];
                end
                r_clip <= div_tag.clip;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_out_x     = r_res[0];
    assign o_out_y     = r_res[1];
    assign o_out_z     = r_res[2];
    assign o_out_w     = r_res[3];
    assign o_w_zero    = r_wz;
    assign o_saturated = r_clip;

endmodule

FILE: hw/rtl/vt4_chk.sv
// port-level checks for vertex_transform_4x4_core, bound to the top level
// depends on vt4_pkg
module vt4_chk import vt4_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [DATA_W-1:0] o_out_x,
    input logic signed [DATA_W-1:0] o_out_y,
    input logic signed [DATA_W-1:0] o_out_z,
    input logic signed [DATA_W-1:0] o_out_w,
    input logic                     o_w_zero,
    input logic                     o_saturated
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result valid after reset");

    // input is held off only by a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("stall without held result");

    // zero-w point result is all zeros and not clipped
    a_wzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_w_zero) |-> (o_out_x == 0 && o_out_y == 0 && o_out_z == 0
                                   && o_out_w == 0 && !o_saturated))
        else $error("zero-w result not cleared");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_x) && $stable(o_out_w)
                                  && $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind vertex_transform_4x4_core vt4_chk u_vt4_chk (.*);
